### src/ljpf_pkg.sv
// ljpf_pkg: shared types, constants and helpers for the lennard-jones pair force block
// no dependencies; imported by ljpf_dpath and lj_pair_force
package ljpf_pkg;

    // divider: one quotient bit per stage, quotient saturates at 2^63 - 1
    localparam int DIV_STEPS  = 63;
    localparam int N_DIV      = 3;
    localparam int D_Q        = 0;
    localparam int D_INV      = 1;
    localparam int D_S        = 2;

    // multiplier slots, six stages each
    localparam int N_MUL      = 16;
    localparam int M_Q2       = 0;
    localparam int M_Q3       = 1;
    localparam int M_Q6       = 2;
    localparam int M_AWQ3     = 3;
    localparam int M_V        = 4;
    localparam int M_E1       = 5;
    localparam int M_W        = 6;
    localparam int M_FT       = 7;
    localparam int M_FX       = 8;
    localparam int M_FY       = 9;
    localparam int M_FZ       = 10;
    localparam int M_S2       = 11;
    localparam int M_S3       = 12;
    localparam int M_S6       = 13;
    localparam int M_AWS3     = 14;
    localparam int M_SH       = 15;

    // alignment of the item pipeline, counted from the r2 stage
    localparam int TAG_LEN    = 102;
    localparam int T_FORCE_IN = 95;
    localparam int T_OUT      = 101;
    localparam int Q_DLY      = 6;
    localparam int INV_DLY    = 25;
    localparam int NRG_DLY    = 11;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [2:0] {
        CFG_BOX_X,
        CFG_BOX_Y,
        CFG_BOX_Z,
        CFG_CUTOFF_SQ,
        CFG_SIGMA_SQ,
        CFG_EPSILON,
        CFG_ATTRACT_WEIGHT,
        CFG_TYPE_PAIR
    } cfg_idx_t;

    typedef struct packed {
        logic [30:0] box_x;
        logic [30:0] box_y;
        logic [30:0] box_z;
        logic [31:0] cutoff_sq;
        logic [31:0] sigma_sq;
        logic [31:0] epsilon;
        logic [31:0] attract_weight;
        logic [15:0] type_pair;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic               live;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
    } tag_t;

    typedef struct packed {
        logic               valid;
        logic signed [63:0] force_x;
        logic signed [63:0] force_y;
        logic signed [63:0] force_z;
        logic signed [31:0] disp_x;
        logic signed [31:0] disp_y;
        logic signed [31:0] disp_z;
        logic signed [63:0] pair_energy;
        logic               interacts;
    } res_t;

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] d;
        d = {a[63], a} - {b[63], b};
        if (d[64] != d[63])
        begin
            return d[64] ? S64_MIN : S64_MAX;
        end
        return d[63:0];
    endfunction

endpackage

### src/ljpf_dpath.sv
// ljpf_dpath: wrap, r2, dividers and multiplier slots of the pair force pipeline
// depends on ljpf_pkg; instantiated by lj_pair_force
module ljpf_dpath
    import ljpf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  logic               in_valid,
    input  logic signed [31:0] pos_ix,
    input  logic signed [31:0] pos_iy,
    input  logic signed [31:0] pos_iz,
    input  logic signed [31:0] pos_jx,
    input  logic signed [31:0] pos_jy,
    input  logic signed [31:0] pos_jz,
    input  logic [7:0]         kind_i,
    input  logic [7:0]         kind_j,
    input  cfg_t               cfg,
    output res_t               res
);

    function automatic logic signed [31:0] wrap_axis(input logic signed [32:0] d,
                                                     input logic [30:0] box);
        logic signed [34:0] dd;
        logic signed [34:0] bb;
        logic signed [34:0] w;
        dd = {{2{d[32]}}, d};
        bb = {4'b0000, box};
        if ((dd <<< 1) > bb)
        begin
            w = dd - bb;
        end
        else if ((dd <<< 1) < -bb)
        begin
            w = dd + bb;
        end
        else
        begin
            w = dd;
        end
        if (w > 35'sd2147483647)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (w < -35'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return w[31:0];
    endfunction

    // front: diff, wrap, square, sum, cutoff test
    logic               a_valid_reg;
    logic signed [32:0] a_d_reg [3];
    logic [7:0]         a_ki_reg;
    logic [7:0]         a_kj_reg;
    logic               b_valid_reg;
    logic               b_match_reg;
    logic signed [31:0] b_d_reg [3];
    logic               c_valid_reg;
    logic               c_match_reg;
    logic signed [31:0] c_d_reg [3];
    logic [63:0]        c_sq_reg [3];
    logic               d_valid_reg;
    logic               d_match_reg;
    logic signed [31:0] d_d_reg [3];
    logic [63:0]        d_r2_reg;
    logic [63:0]        e_r2_reg;
    tag_t               tag_reg [TAG_LEN];

    logic [7:0]  type_a;
    logic [7:0]  type_b;

    assign type_a = cfg.type_pair[7:0];
    assign type_b = cfg.type_pair[15:8];

    // magnitudes of the wrapped displacements feed the squares
    logic [31:0] b_mag [3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            b_mag[k] = b_d_reg[k][31] ? (~b_d_reg[k] + 32'd1) : b_d_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            for (int i = 0; i < TAG_LEN; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else if (step_en)
        begin
            a_valid_reg   <= in_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            tag_reg[0].valid <= d_valid_reg;
            tag_reg[0].live  <= d_match_reg && (d_r2_reg != 64'd0)
                                && (d_r2_reg < {16'b0, cfg.cutoff_sq, 16'b0});
            tag_reg[0].dx    <= d_d_reg[0];
            tag_reg[0].dy    <= d_d_reg[1];
            tag_reg[0].dz    <= d_d_reg[2];
            for (int i = 1; i < TAG_LEN; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            a_d_reg[0] <= {pos_ix[31], pos_ix} - {pos_jx[31], pos_jx};
            a_d_reg[1] <= {pos_iy[31], pos_iy} - {pos_jy[31], pos_jy};
            a_d_reg[2] <= {pos_iz[31], pos_iz} - {pos_jz[31], pos_jz};
            a_ki_reg   <= kind_i;
            a_kj_reg   <= kind_j;
            b_match_reg <= ((a_ki_reg == type_a) && (a_kj_reg == type_b))
                           || ((a_ki_reg == type_b) && (a_kj_reg == type_a));
            b_d_reg[0] <= wrap_axis(a_d_reg[0], cfg.box_x);
            b_d_reg[1] <= wrap_axis(a_d_reg[1], cfg.box_y);
            b_d_reg[2] <= wrap_axis(a_d_reg[2], cfg.box_z);
            c_match_reg <= b_match_reg;
            d_match_reg <= c_match_reg;
            for (int k = 0; k < 3; k++)
            begin
                c_d_reg[k]  <= b_d_reg[k];
                c_sq_reg[k] <= b_mag[k] * b_mag[k];
                d_d_reg[k]  <= c_d_reg[k];
            end
            d_r2_reg <= c_sq_reg[0] + c_sq_reg[1] + c_sq_reg[2];
            e_r2_reg <= d_r2_reg;
        end
    end

    // dividers: quotient of num * 2^32 / den, one bit per stage
    logic [47:0]        div_num [N_DIV];
    logic [63:0]        div_den [N_DIV];
    logic [N_DIV-1:0]   div_en;
    logic signed [63:0] div_q   [N_DIV];

    always_comb
    begin
        div_num[D_Q]   = {cfg.sigma_sq, 16'b0};
        div_den[D_Q]   = e_r2_reg;
        div_num[D_INV] = 48'h0001_0000_0000;
        div_den[D_INV] = e_r2_reg;
        div_num[D_S]   = {cfg.sigma_sq, 16'b0};
        div_den[D_S]   = {16'b0, cfg.cutoff_sq, 16'b0};
        div_en[D_Q]    = step_en;
        div_en[D_INV]  = step_en;
        div_en[D_S]    = 1'b1;
    end

    for (genvar g = 0; g < N_DIV; g++)
    begin : g_div
        logic [63:0] rem_reg [DIV_STEPS];
        logic [63:0] den_reg [DIV_STEPS];
        logic [30:0] nlo_reg [DIV_STEPS];
        logic [62:0] quo_reg [DIV_STEPS+1];
        logic        sat_reg [DIV_STEPS+1];
        logic [64:0] trial   [DIV_STEPS];
        logic [DIV_STEPS-1:0] take;

        always_comb
        begin
            for (int s = 0; s < DIV_STEPS; s++)
            begin
                trial[s] = {rem_reg[s], nlo_reg[s][30]};
                take[s]  = trial[s] >= {1'b0, den_reg[s]};
            end
        end

        always_ff @(posedge clk)
        begin
            if (div_en[g])
            begin
                rem_reg[0] <= {47'b0, div_num[g][47:31]};
                den_reg[0] <= div_den[g];
                nlo_reg[0] <= div_num[g][30:0];
                quo_reg[0] <= '0;
                sat_reg[0] <= {47'b0, div_num[g][47:31]} >= div_den[g];
                for (int s = 0; s < DIV_STEPS; s++)
                begin
                    if (s < DIV_STEPS - 1)
                    begin
                        rem_reg[s+1] <= take[s] ? 64'(trial[s] - {1'b0, den_reg[s]})
                                                : trial[s][63:0];
                        den_reg[s+1] <= den_reg[s];
                        nlo_reg[s+1] <= {nlo_reg[s][29:0], 1'b0};
                    end
                    quo_reg[s+1] <= {quo_reg[s][61:0], take[s]};
                    sat_reg[s+1] <= sat_reg[s];
                end
            end
        end

        assign div_q[g] = sat_reg[DIV_STEPS] ? S64_MAX : {1'b0, quo_reg[DIV_STEPS]};
    end

    // multiplier slots: rounded, saturated q32.32 product
    logic signed [63:0] mul_a [N_MUL];
    logic signed [63:0] mul_b [N_MUL];
    logic signed [63:0] mul_p [N_MUL];
    logic [N_MUL-1:0]   mul_en;

    for (genvar g = 0; g < N_MUL; g++)
    begin : g_mul
        logic [63:0]        ma_reg;
        logic [63:0]        mb_reg;
        logic               n1_reg;
        logic [63:0]        p00_reg;
        logic [63:0]        p01_reg;
        logic [63:0]        p10_reg;
        logic [63:0]        p11_reg;
        logic               n2_reg;
        logic [64:0]        mid_reg;
        logic [63:0]        lo_reg;
        logic [63:0]        hi_reg;
        logic               n3_reg;
        logic [127:0]       prod_reg;
        logic               n4_reg;
        logic [127:0]       rnd_reg;
        logic               n5_reg;
        logic signed [63:0] res_reg;
        logic [63:0]        mag64;

        assign mag64 = {1'b0, rnd_reg[94:32]};

        always_ff @(posedge clk)
        begin
            if (mul_en[g])
            begin
                ma_reg   <= mul_a[g][63] ? (~mul_a[g] + 64'd1) : mul_a[g];
                mb_reg   <= mul_b[g][63] ? (~mul_b[g] + 64'd1) : mul_b[g];
                n1_reg   <= mul_a[g][63] ^ mul_b[g][63];
                p00_reg  <= ma_reg[31:0] * mb_reg[31:0];
                p01_reg  <= ma_reg[31:0] * mb_reg[63:32];
                p10_reg  <= ma_reg[63:32] * mb_reg[31:0];
                p11_reg  <= ma_reg[63:32] * mb_reg[63:32];
                n2_reg   <= n1_reg;
                mid_reg  <= {1'b0, p01_reg} + {1'b0, p10_reg};
                lo_reg   <= p00_reg;
                hi_reg   <= p11_reg;
                n3_reg   <= n2_reg;
                prod_reg <= {hi_reg, lo_reg} + {31'b0, mid_reg, 32'b0};
                n4_reg   <= n3_reg;
                rnd_reg  <= prod_reg + 128'h8000_0000;
                n5_reg   <= n4_reg;
                if (|rnd_reg[127:95])
                begin
                    res_reg <= n5_reg ? S64_MIN : S64_MAX;
                end
                else
                begin
                    res_reg <= n5_reg ? (~mag64 + 64'd1) : mag64;
                end
            end
        end

        assign mul_p[g] = res_reg;
    end

    // derived constants from configuration
    logic signed [63:0] eps4;
    logic signed [63:0] eps48_reg;
    logic signed [63:0] aw;
    logic signed [63:0] awh;

    assign eps4 = {14'b0, cfg.epsilon, 18'b0};
    assign aw   = {16'b0, cfg.attract_weight, 16'b0};
    assign awh  = {17'b0, cfg.attract_weight, 15'b0};

    always_ff @(posedge clk)
    begin
        eps48_reg <= ({16'b0, cfg.epsilon, 16'b0} << 5) + ({16'b0, cfg.epsilon, 16'b0} << 4);
    end

    // shift lane, free running on configuration
    logic signed [63:0] st_reg;

    always_ff @(posedge clk)
    begin
        st_reg <= sat_sub(mul_p[M_S6], mul_p[M_AWS3]);
    end

    // item lane glue and alignment
    logic signed [63:0] q_dly_reg   [Q_DLY];
    logic signed [63:0] inv_dly_reg [INV_DLY];
    logic signed [63:0] nrg_dly_reg [NRG_DLY];
    logic signed [63:0] q3_d1_reg;
    logic signed [63:0] u_reg;
    logic signed [63:0] t_reg;
    logic signed [63:0] nrg_reg;
    logic signed [63:0] fin_d [3];

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            q_dly_reg[0]   <= div_q[D_Q];
            inv_dly_reg[0] <= div_q[D_INV];
            nrg_dly_reg[0] <= nrg_reg;
            for (int i = 1; i < Q_DLY; i++)
            begin
                q_dly_reg[i] <= q_dly_reg[i-1];
            end
            for (int i = 1; i < INV_DLY; i++)
            begin
                inv_dly_reg[i] <= inv_dly_reg[i-1];
            end
            for (int i = 1; i < NRG_DLY; i++)
            begin
                nrg_dly_reg[i] <= nrg_dly_reg[i-1];
            end
            q3_d1_reg <= mul_p[M_Q3];
            u_reg     <= sat_sub(mul_p[M_Q3], awh);
            t_reg     <= sat_sub(mul_p[M_Q6], mul_p[M_AWQ3]);
            nrg_reg   <= sat_sub(mul_p[M_E1], mul_p[M_SH]);
        end
    end

    assign fin_d[0] = {{16{tag_reg[T_FORCE_IN].dx[31]}}, tag_reg[T_FORCE_IN].dx, 16'b0};
    assign fin_d[1] = {{16{tag_reg[T_FORCE_IN].dy[31]}}, tag_reg[T_FORCE_IN].dy, 16'b0};
    assign fin_d[2] = {{16{tag_reg[T_FORCE_IN].dz[31]}}, tag_reg[T_FORCE_IN].dz, 16'b0};

    always_comb
    begin
        mul_a[M_Q2]   = div_q[D_Q];          mul_b[M_Q2]   = div_q[D_Q];
        mul_a[M_Q3]   = mul_p[M_Q2];         mul_b[M_Q3]   = q_dly_reg[Q_DLY-1];
        mul_a[M_Q6]   = mul_p[M_Q3];         mul_b[M_Q6]   = mul_p[M_Q3];
        mul_a[M_AWQ3] = aw;                  mul_b[M_AWQ3] = mul_p[M_Q3];
        mul_a[M_V]    = q3_d1_reg;           mul_b[M_V]    = u_reg;
        mul_a[M_E1]   = eps4;                mul_b[M_E1]   = t_reg;
        mul_a[M_W]    = eps48_reg;           mul_b[M_W]    = mul_p[M_V];
        mul_a[M_FT]   = mul_p[M_W];          mul_b[M_FT]   = inv_dly_reg[INV_DLY-1];
        mul_a[M_FX]   = mul_p[M_FT];         mul_b[M_FX]   = fin_d[0];
        mul_a[M_FY]   = mul_p[M_FT];         mul_b[M_FY]   = fin_d[1];
        mul_a[M_FZ]   = mul_p[M_FT];         mul_b[M_FZ]   = fin_d[2];
        mul_a[M_S2]   = div_q[D_S];          mul_b[M_S2]   = div_q[D_S];
        mul_a[M_S3]   = mul_p[M_S2];         mul_b[M_S3]   = div_q[D_S];
        mul_a[M_S6]   = mul_p[M_S3];         mul_b[M_S6]   = mul_p[M_S3];
        mul_a[M_AWS3] = aw;                  mul_b[M_AWS3] = mul_p[M_S3];
        mul_a[M_SH]   = eps4;                mul_b[M_SH]   = st_reg;
        for (int i = 0; i < N_MUL; i++)
        begin
            mul_en[i] = (i < M_S2) ? step_en : 1'b1;
        end
    end

    // final stage: zero the forces, displacements and energy for pairs that do not interact
    logic live_out;

    assign live_out = tag_reg[T_OUT].live;

    always_comb
    begin
        res.valid       = tag_reg[T_OUT].valid;
        res.interacts   = live_out;
        res.force_x     = live_out ? mul_p[M_FX] : '0;
        res.force_y     = live_out ? mul_p[M_FY] : '0;
        res.force_z     = live_out ? mul_p[M_FZ] : '0;
        res.disp_x      = live_out ? tag_reg[T_OUT].dx : '0;
        res.disp_y      = live_out ? tag_reg[T_OUT].dy : '0;
        res.disp_z      = live_out ? tag_reg[T_OUT].dz : '0;
        res.pair_energy = live_out ? nrg_dly_reg[NRG_DLY-1] : '0;
    end

endmodule

### src/lj_pair_force.sv
// lj_pair_force: an accepted request reaches the output through the datapath and output register
// throughput one request per cycle while in_stall is low; the pipeline moves as one unit and holds
// while a result sits in the output register under out_stall; the critical path is one 65-bit
// divider step; the energy shift is formed by a free-running lane on the configuration; rst_n
// clears config to defaults, all valid bits and the tag shift register; other payload is not reset
module lj_pair_force
    import ljpf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration write port
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    // request channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] pos_ix,
    input  logic signed [31:0] pos_iy,
    input  logic signed [31:0] pos_iz,
    input  logic signed [31:0] pos_jx,
    input  logic signed [31:0] pos_jy,
    input  logic signed [31:0] pos_jz,
    input  logic [7:0]         kind_i,
    input  logic [7:0]         kind_j,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [63:0] force_x,
    output logic signed [63:0] force_y,
    output logic signed [63:0] force_z,
    output logic signed [31:0] disp_x,
    output logic signed [31:0] disp_y,
    output logic signed [31:0] disp_z,
    output logic signed [63:0] pair_energy,
    output logic               interacts
);

    // configuration registers
    logic [30:0] box_x_reg;
    logic [30:0] box_y_reg;
    logic [30:0] box_z_reg;
    logic [31:0] cutoff_sq_reg;
    logic [31:0] sigma_sq_reg;
    logic [31:0] epsilon_reg;
    logic [31:0] attract_weight_reg;
    logic [15:0] type_pair_reg;
    cfg_t        cfg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_x_reg          <= 31'd655360;
            box_y_reg          <= 31'd655360;
            box_z_reg          <= 31'd655360;
            cutoff_sq_reg      <= 32'd409600;
            sigma_sq_reg       <= 32'd65536;
            epsilon_reg        <= 32'd65536;
            attract_weight_reg <= 32'd65536;
            type_pair_reg      <= 16'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_BOX_X:          box_x_reg          <= cfg_data[30:0];
                CFG_BOX_Y:          box_y_reg          <= cfg_data[30:0];
                CFG_BOX_Z:          box_z_reg          <= cfg_data[30:0];
                CFG_CUTOFF_SQ:      cutoff_sq_reg      <= cfg_data;
                CFG_SIGMA_SQ:       sigma_sq_reg       <= cfg_data;
                CFG_EPSILON:        epsilon_reg        <= cfg_data;
                CFG_ATTRACT_WEIGHT: attract_weight_reg <= cfg_data;
                CFG_TYPE_PAIR:      type_pair_reg      <= cfg_data[15:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        cfg.box_x          = box_x_reg;
        cfg.box_y          = box_y_reg;
        cfg.box_z          = box_z_reg;
        cfg.cutoff_sq      = cutoff_sq_reg;
        cfg.sigma_sq       = sigma_sq_reg;
        cfg.epsilon        = epsilon_reg;
        cfg.attract_weight = attract_weight_reg;
        cfg.type_pair      = type_pair_reg;
    end

    // pipeline advance: any cycle in which the output register is free or being taken
    logic out_valid_reg;
    logic adv;
    res_t pipe_res;
    res_t out_reg;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    ljpf_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (adv),
        .in_valid (in_valid),
        .pos_ix   (pos_ix),
        .pos_iy   (pos_iy),
        .pos_iz   (pos_iz),
        .pos_jx   (pos_jx),
        .pos_jy   (pos_jy),
        .pos_jz   (pos_jz),
        .kind_i   (kind_i),
        .kind_j   (kind_j),
        .cfg      (cfg),
        .res      (pipe_res)
    );

    // output register splits the result channel from the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= pipe_res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= pipe_res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign force_x     = out_reg.force_x;
    assign force_y     = out_reg.force_y;
    assign force_z     = out_reg.force_z;
    assign disp_x      = out_reg.disp_x;
    assign disp_y      = out_reg.disp_y;
    assign disp_z      = out_reg.disp_z;
    assign pair_energy = out_reg.pair_energy;
    assign interacts   = out_reg.interacts;

endmodule

### src/ljpf_chk.sv
// ljpf_chk: port-level checks for lj_pair_force, attached by bind
// depends only on the top level's ports
module ljpf_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic signed [31:0] pos_ix,
    input logic signed [31:0] pos_iy,
    input logic signed [31:0] pos_iz,
    input logic signed [31:0] pos_jx,
    input logic signed [31:0] pos_jy,
    input logic signed [31:0] pos_jz,
    input logic [7:0]         kind_i,
    input logic [7:0]         kind_j,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [63:0] force_x,
    input logic signed [63:0] force_y,
    input logic signed [63:0] force_z,
    input logic signed [31:0] disp_x,
    input logic signed [31:0] disp_y,
    input logic signed [31:0] disp_z,
    input logic signed [63:0] pair_energy,
    input logic               interacts
);

    // a pair that does not interact carries an all-zero result
    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !interacts |-> force_x == 0 && force_y == 0 && force_z == 0
            && disp_x == 0 && disp_y == 0 && disp_z == 0 && pair_energy == 0)
        else $error("non-interacting result not zero");

    // an interacting pair never has zero displacement
    a_nonzero_disp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && interacts |-> !(disp_x == 0 && disp_y == 0 && disp_z == 0))
        else $error("interacting pair with zero displacement");

    // requests are held back only while a result waits under stall
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("request stalled without a blocked result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pair_energy) && $stable(interacts)
            && $stable(force_x) && $stable(disp_x))
        else $error("stalled result changed");

    // a stalled request stays in place
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(pos_ix) && $stable(pos_iy)
            && $stable(pos_iz) && $stable(pos_jx) && $stable(pos_jy) && $stable(pos_jz)
            && $stable(kind_i) && $stable(kind_j))
        else $error("stalled request changed");

endmodule

bind lj_pair_force ljpf_chk u_ljpf_chk (.*);
